// ===== design/rrwt_pkg.sv =====
// Shared types and constants for the round-robin wait-time block.
// No dependencies; imported by every module of the block.
package rrwt_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    localparam int BURST_W = 12;
    localparam int TIME_W  = 16;
    localparam int SUM_W   = 20;
    localparam int PIDX_W  = 4;

    localparam logic [BURST_W-1:0] QUANTUM_RESET = BURST_W'(2);

    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic               last_process;
    } rrwt_item_t;

    typedef struct packed {
        logic [PIDX_W-1:0] process_index;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [SUM_W-1:0]  total_wait;
        logic [SUM_W-1:0]  total_turnaround;
        logic              last_result;
    } rrwt_result_t;

    // controller -> datapath
    typedef struct packed {
        logic             load;   // write burst at addr
        logic             start;  // clear simulation clock
        logic             step;   // serve process at addr
        logic             emit;   // build result for process at addr
        logic             first;  // restart running totals
        logic             last;   // final result of the batch
        logic [IDX_W-1:0] addr;
    } rrwt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic active;    // process at addr still owes service
        logic out_free;  // result register can take a new result
    } rrwt_status_t;

endpackage

// ===== design/rrwt_ctrl.sv =====
// Controller for the round-robin wait-time block: load, sweep and emit phases.
// Depends on rrwt_pkg; drives rrwt_dp through rrwt_cmd_t.
module rrwt_ctrl
    import rrwt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         last_process,
    output logic         item_stall,
    input  rrwt_status_t status,
    output rrwt_cmd_t    cmd
);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             busy_reg, busy_next;

    logic [CNT_W-1:0] count_m1;
    logic             at_end;
    logic             pass_busy;
    logic             accept;

    assign count_m1   = CNT_W'(count_reg - 1'b1);
    assign at_end     = (k_reg == count_m1[IDX_W-1:0]);
    assign pass_busy  = busy_reg | status.active;
    assign item_stall = (state_reg != S_LOAD);
    assign accept     = item_valid & ~item_stall;

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        busy_next     = busy_reg;
        cmd           = '0;
        cmd.addr      = k_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.addr = load_cnt_reg[IDX_W-1:0];
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (last_process || (load_cnt_reg == CNT_W'(MAX_PROCESSES - 1)))
                    begin
                        cmd.start     = 1'b1;
                        count_next    = CNT_W'(load_cnt_reg + 1'b1);
                        load_cnt_next = '0;
                        k_next        = '0;
                        busy_next     = 1'b0;
                        state_next    = S_RUN;
                    end
                    else
                    begin
                        load_cnt_next = CNT_W'(load_cnt_reg + 1'b1);
                    end
                end
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (at_end)
                begin
                    k_next    = '0;
                    busy_next = 1'b0;
                    if (!pass_busy)
                        state_next = S_EMIT;
                end
                else
                begin
                    k_next    = IDX_W'(k_reg + 1'b1);
                    busy_next = pass_busy;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.first = (k_reg == '0);
                    cmd.last  = at_end;
                    if (at_end)
                    begin
                        k_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next = IDX_W'(k_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

// ===== design/rrwt_dp.sv =====
// Datapath for the round-robin wait-time block: stores, clock, quantum, result register.
// Depends on rrwt_pkg; commanded by rrwt_ctrl.
module rrwt_dp
    import rrwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               quantum_we,
    input  logic [BURST_W-1:0] quantum_data,
    input  logic [BURST_W-1:0] burst_time,
    input  rrwt_cmd_t          cmd,
    output rrwt_status_t       status,
    output logic               result_valid,
    input  logic               result_stall,
    output rrwt_result_t       result
);

    logic [BURST_W-1:0] burst_mem  [MAX_PROCESSES];
    logic [BURST_W-1:0] remain_mem [MAX_PROCESSES];
    logic [TIME_W-1:0]  wait_mem   [MAX_PROCESSES];

    logic [BURST_W-1:0] quantum_reg;
    logic [TIME_W-1:0]  sim_clock_reg, sim_clock_next;
    logic               result_valid_reg;
    rrwt_result_t       result_reg;

    logic [BURST_W-1:0] slice;
    logic [BURST_W-1:0] left;
    logic [BURST_W-1:0] burst_k;
    logic               partial;
    logic [TIME_W-1:0]  wait_k;
    logic [TIME_W-1:0]  turn_k;
    logic [SUM_W-1:0]   sum_w_base, sum_t_base;

    assign slice   = (quantum_reg == '0) ? BURST_W'(1) : quantum_reg;
    assign left    = remain_mem[cmd.addr];
    assign burst_k = burst_mem[cmd.addr];
    assign partial = (left > slice);
    assign wait_k  = wait_mem[cmd.addr];
    assign turn_k  = TIME_W'(TIME_W'(burst_k) + wait_k);

    assign sum_w_base = cmd.first ? '0 : result_reg.total_wait;
    assign sum_t_base = cmd.first ? '0 : result_reg.total_turnaround;

    assign status.active   = (left != '0);
    assign status.out_free = ~result_valid_reg | ~result_stall;

    always_comb
    begin
        sim_clock_next = sim_clock_reg;
        if (cmd.start)
            sim_clock_next = '0;
        else if (cmd.step && status.active)
            sim_clock_next = TIME_W'(sim_clock_reg + TIME_W'(partial ? slice : left));
    end

    // stores: loaded with zero wait and full remainder, updated per served turn
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            burst_mem[cmd.addr]  <= burst_time;
            remain_mem[cmd.addr] <= burst_time;
            wait_mem[cmd.addr]   <= '0;
        end
        else if (cmd.step && status.active)
        begin
            if (partial)
            begin
                remain_mem[cmd.addr] <= BURST_W'(left - slice);
            end
            else
            begin
                remain_mem[cmd.addr] <= '0;
                wait_mem[cmd.addr]   <= TIME_W'(sim_clock_next - TIME_W'(burst_k));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.process_index    <= PIDX_W'(cmd.addr);
            result_reg.wait_time        <= wait_k;
            result_reg.turnaround_time  <= turn_k;
            result_reg.total_wait       <= SUM_W'(sum_w_base + SUM_W'(wait_k));
            result_reg.total_turnaround <= SUM_W'(sum_t_base + SUM_W'(turn_k));
            result_reg.last_result      <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg      <= QUANTUM_RESET;
            sim_clock_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (quantum_we)
                quantum_reg <= quantum_data;
            sim_clock_reg <= sim_clock_next;
            if (cmd.emit)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/round_robin_wait_time.sv =====
// Round-robin wait-time block: loading accepts one transaction per cycle, no stall.
// After the final burst, the sweep visits each process once in each of
// ceil(max_burst / quantum) + 1 passes, then emits count results, one per
// cycle unless stalled. The next batch loads while the last result still waits
// in the output register. Reset (rst_n, async, active low): loading phase, empty
// batch, quantum = 2, no result pending; the process stores hold no reset value.
module round_robin_wait_time
    import rrwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration: quantum register
    input  logic               quantum_we,
    input  logic [BURST_W-1:0] quantum_data,
    // burst input channel
    input  logic               item_valid,
    output logic               item_stall,
    input  rrwt_item_t         item,
    // result output channel
    output logic               result_valid,
    input  logic               result_stall,
    output rrwt_result_t       result
);

    rrwt_cmd_t    cmd;
    rrwt_status_t status;

    // Controller: the only place with phase state. It stalls input transactions
    // during the sweep and the emit phase, and walks the process index one
    // entry per cycle in both; in the emit phase only while the output is free.
    rrwt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .last_process (item.last_process),
        .item_stall   (item_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath: burst/remainder/wait stores, simulation clock, the quantum
    // register, and the registered result with its running totals.
    rrwt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .quantum_we   (quantum_we),
        .quantum_data (quantum_data),
        .burst_time   (item.burst_time),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== design/rrwt_checker.sv =====
// Port-level checks for round_robin_wait_time, attached with a bind.
// Depends on rrwt_pkg.
module rrwt_checker
    import rrwt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         item_valid,
    input logic         item_stall,
    input rrwt_item_t   item,
    input logic         result_valid,
    input logic         result_stall,
    input rrwt_result_t result
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // closing the batch stops further loads
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.last_process |=> item_stall)
        else $error("input not stalled after final burst");

    // first result starts the running totals
    a_first_totals: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.process_index == '0) |->
            (result.total_wait == SUM_W'(result.wait_time)) &&
            (result.total_turnaround == SUM_W'(result.turnaround_time)))
        else $error("totals not restarted at first process");

    // turnaround includes the wait
    a_turn_ge_wait: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.turnaround_time >= result.wait_time)
        else $error("turnaround below wait");

endmodule

bind round_robin_wait_time rrwt_checker u_rrwt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== tb/tb_round_robin_wait_time.sv =====
// Self-checking testbench for round_robin_wait_time: round-robin waiting and
// turnaround times per batch of bursts, checked against an in-bench predictor.
// Depends on rrwt_pkg and round_robin_wait_time from the design folder.
`timescale 1ns / 1ps

module tb_round_robin_wait_time;
    import rrwt_pkg::*;

    // Run bounds. Worst single batch here is one burst of 4095 at quantum 2;
    // every random batch is kept to a few dozen passes. Roughly 60 batches plus
    // result stalls stay well under the limit below, with several times margin.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int CFG_SETTLE    = 20;   // idle cycles before a quantum write
    localparam int END_SETTLE    = 100;  // quiet cycles after the last result
    localparam int HOLD_CYCLES   = 400;  // long receiver hold-off for back-pressure
    localparam int RANDOM_ITEMS  = 340;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               quantum_we = 1'b0;
    logic [BURST_W-1:0] quantum_data = '0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    rrwt_item_t         item = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    rrwt_result_t       result;

    // Transactions waiting to be offered, and results owed by closed batches.
    rrwt_item_t   burst_queue[$];
    rrwt_result_t owed_results[$];

    // Predictor state: quantum register and the batch being loaded.
    logic [BURST_W-1:0] model_quantum = QUANTUM_RESET;
    logic [BURST_W-1:0] loaded_bursts [MAX_PROCESSES];
    int                 loaded_count = 0;

    int  errors = 0;
    int  cycles = 0;
    int  bursts_sent = 0;
    int  batches_closed = 0;
    int  results_checked = 0;
    int  quanta_used = 1;
    bit  item_fire_q = 1'b0;
    int  gap_left = 0;
    int  gap_rate = 50;      // percent of transactions followed by a sender gap
    int  stall_left = 0;
    int  free_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_off = 1'b0;

    round_robin_wait_time u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .quantum_we   (quantum_we),
        .quantum_data (quantum_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one. Never zero.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Round-robin sweep over the closed batch; queues one result per process.
    function automatic void schedule_batch(int count);
        logic [BURST_W-1:0] left [MAX_PROCESSES];
        logic [TIME_W-1:0]  waits [MAX_PROCESSES];
        logic [TIME_W-1:0]  now_t;
        logic [TIME_W-1:0]  turn;
        logic [BURST_W-1:0] slice;
        logic [SUM_W-1:0]   sum_w;
        logic [SUM_W-1:0]   sum_t;
        bit                 busy;
        rrwt_result_t       r;
        slice = (model_quantum == '0) ? BURST_W'(1) : model_quantum;
        now_t = '0;
        for (int k = 0; k < count; k++)
        begin
            left[k]  = loaded_bursts[k];
            waits[k] = '0;      // zero bursts are never served: wait stays 0
        end
        busy = 1'b1;
        while (busy)
        begin
            busy = 1'b0;
            for (int k = 0; k < count; k++)
            begin
                if (left[k] != '0)
                begin
                    busy = 1'b1;
                    if (left[k] > slice)
                    begin
                        now_t   = now_t + TIME_W'(slice);
                        left[k] = left[k] - slice;
                    end
                    else
                    begin
                        now_t    = now_t + TIME_W'(left[k]);
                        waits[k] = now_t - TIME_W'(loaded_bursts[k]);
                        left[k]  = '0;
                    end
                end
            end
        end
        sum_w = '0;
        sum_t = '0;
        for (int k = 0; k < count; k++)
        begin
            turn  = TIME_W'(loaded_bursts[k]) + waits[k];
            sum_w = sum_w + SUM_W'(waits[k]);
            sum_t = sum_t + SUM_W'(turn);
            r.process_index    = PIDX_W'(k);
            r.wait_time        = waits[k];
            r.turnaround_time  = turn;
            r.total_wait       = sum_w;
            r.total_turnaround = sum_t;
            r.last_result      = (k == count - 1);
            owed_results.push_back(r);
        end
        batches_closed++;
    endfunction

    // One accepted burst: store it, close the batch on the last flag or a full store.
    function automatic void load_burst(rrwt_item_t it);
        loaded_bursts[loaded_count] = it.burst_time;
        loaded_count++;
        if (it.last_process || loaded_count == MAX_PROCESSES)
        begin
            schedule_batch(loaded_count);
            loaded_count = 0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Monitor: outputs sampled at the rising edge. Check before predicting so
    // the owed queue is always in transaction order.
    always @(posedge clk)
    begin : monitor
        rrwt_result_t want;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result transaction with nothing owed (process %0d)",
                           result.process_index);
                    errors++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("process_index", 32'(want.process_index),
                                32'(result.process_index));
                    check_field("wait_time", 32'(want.wait_time), 32'(result.wait_time));
                    check_field("turnaround_time", 32'(want.turnaround_time),
                                32'(result.turnaround_time));
                    check_field("total_wait", 32'(want.total_wait),
                                32'(result.total_wait));
                    check_field("total_turnaround", 32'(want.total_turnaround),
                                32'(result.total_turnaround));
                    check_field("last_result", 32'(want.last_result),
                                32'(result.last_result));
                    results_checked++;
                end
            end
            if (item_valid && !item_stall)
            begin
                load_burst(item);
                bursts_sent++;
            end
            item_fire_q <= item_valid && !item_stall;
        end
    end

    // Driver: payload changes only at the falling edge, and only once the
    // current transaction has gone through.
    always @(negedge clk)
    begin : driver
        if (rst_n && (!item_valid || item_fire_q))
        begin
            if (item_valid)
                gap_left = ($urandom_range(0, 99) < gap_rate) ? pick_gap() : 0;
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (burst_queue.size() > 0)
            begin
                item       <= burst_queue.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: runs of free cycles (sometimes long) broken by stalls.
    always @(negedge clk)
    begin : receiver
        if (stall_left == 0 && free_left == 0)
        begin
            free_left = $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0)
                free_left += 60;
            stall_left = pick_gap();
        end
        if (free_left > 0)
        begin
            free_left--;
            result_stall <= hold_off;
        end
        else
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
    end

    // One long hold-off while the sender keeps offering, so the block backs up.
    initial
    begin : hold_off_proc
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic push_burst(int burst, bit last);
        rrwt_item_t it;
        it.burst_time   = BURST_W'(burst);
        it.last_process = last;
        burst_queue.push_back(it);
    endtask

    // Wait until every transaction is in and every owed result is out.
    task automatic drain(int settle);
        while (burst_queue.size() != 0 || item_valid || owed_results.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_quantum(int q);
        drain(CFG_SETTLE);
        quantum_we   <= 1'b1;
        quantum_data <= BURST_W'(q);
        @(negedge clk);
        quantum_we    <= 1'b0;
        model_quantum  = BURST_W'(q);
        quanta_used++;
        @(posedge clk);    // queue new transactions away from the driver's edge
    endtask

    // Bursts sized so a batch needs only a handful of passes at this quantum,
    // with zero bursts, exact quantum multiples and a few full-range values.
    function automatic int draw_burst(int q);
        int s, top, r;
        s = (q == 0) ? 1 : q;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1 && s >= 256)
            return $urandom_range(0, 4095);
        if (r == 2)
        begin
            top = s * $urandom_range(1, 4);
            return (top > 4095) ? 4095 : top;
        end
        top = s * $urandom_range(1, 12);
        if (top > 4095)
            top = 4095;
        return $urandom_range(1, top);
    endfunction

    // Well-formed batch: last flag on the final burst; a full batch of 16
    // sometimes closes on the full store with the flag left low.
    task automatic queue_batch(int q);
        int count;
        bit last;
        count = ($urandom_range(0, 5) == 0) ? MAX_PROCESSES : $urandom_range(1, 10);
        for (int i = 0; i < count; i++)
        begin
            last = 1'b0;
            if (i == count - 1)
                last = (count == MAX_PROCESSES) ? 1'($urandom_range(0, 1)) : 1'b1;
            push_burst(draw_burst(q), last);
        end
    endtask

    initial
    begin : sequencer
        int q;
        int phase;
        int queued;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset quantum of 2: single max burst, single zero burst,
        // then a mix with a zero burst in the middle.
        gap_rate = 0;
        push_burst(4095, 1'b1);
        push_burst(0, 1'b1);
        push_burst(3, 1'b0);
        push_burst(0, 1'b0);
        push_burst(5, 1'b0);
        push_burst(1, 1'b1);

        // Zero quantum acts as a quantum of 1.
        set_quantum(0);
        gap_rate = 50;
        push_burst(1, 1'b0);
        push_burst(2, 1'b0);
        push_burst(3, 1'b1);

        // Max quantum, full store of max bursts closing with the flag low.
        set_quantum(4095);
        for (int i = 0; i < MAX_PROCESSES; i++)
            push_burst(4095, 1'b0);

        // Random phases, each under its own quantum.
        queued = 0;
        phase  = 0;
        while (queued < RANDOM_ITEMS)
        begin
            case (phase)
                0:       q = 1;
                1:       q = 4095;
                default:
                    case ($urandom_range(0, 5))
                        0:       q = 0;
                        1:       q = $urandom_range(1, 8);
                        2:       q = 4095;
                        default: q = $urandom_range(1, 4095);
                    endcase
            endcase
            set_quantum(q);
            gap_rate = (phase % 3 == 1) ? 0 : $urandom_range(10, 80);
            if (phase == 2)
                hold_req = 1'b1;
            for (int b = $urandom_range(2, 5); b > 0; b--)
            begin
                queue_batch(q);
            end
            queued += burst_queue.size();
            phase++;
        end

        drain(END_SETTLE);
        $display("covered %0d bursts in %0d batches over %0d quantum settings",
                 bursts_sent, batches_closed, quanta_used);
        $display("%0d result transactions checked in %0d cycles", results_checked, cycles);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rrwt_pkg.sv
design/rrwt_ctrl.sv
design/rrwt_dp.sv
design/round_robin_wait_time.sv
design/rrwt_checker.sv
tb/tb_round_robin_wait_time.sv
